FILE: design/gi2d_pkg.sv
// Package for the 2D grid interpolator: payload word types, mode codes,
// register indexes and weight constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gi2d_pkg;

  typedef struct packed {
    logic               kind;
    logic        [5:0]  load_row;
    logic        [5:0]  load_col;
    logic signed [15:0] load_value;
    logic signed [31:0] query_pos_row;
    logic signed [31:0] query_pos_col;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic               outside_grid;
    logic               used_nearest;
  } out_word_t;

  localparam logic       KIND_LOAD  = 1'b0;
  localparam logic       KIND_QUERY = 1'b1;

  localparam logic [1:0] MODE_BILINEAR = 2'd0;
  localparam logic [1:0] MODE_NEAREST  = 2'd1;
  localparam logic [1:0] MODE_LIN_ROWS = 2'd2;
  localparam logic [1:0] MODE_LIN_COLS = 2'd3;

  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_NIL_VALUE    = 3'd1;
  localparam logic [2:0] REG_ROW_ORIGIN   = 3'd2;
  localparam logic [2:0] REG_COL_ORIGIN   = 3'd3;
  localparam logic [2:0] REG_ROW_INV_STEP = 3'd4;
  localparam logic [2:0] REG_COL_INV_STEP = 3'd5;
  localparam logic [2:0] REG_ROW_COUNT    = 3'd6;
  localparam logic [2:0] REG_COL_COUNT    = 3'd7;

  localparam int         CFG_IDX_W  = 4;
  localparam int         CFG_DATA_W = 32;

  // weight in Q0.16 with 17 bits so one is representable
  localparam logic [16:0] WEIGHT_ONE  = 17'h10000;
  localparam logic [16:0] HALF_WEIGHT = 17'h08000;

  // per-axis locate result
  typedef struct packed {
    logic        in_grid;
    logic [9:0]  idx;
    logic [16:0] w;
  } axis_loc_t;

endpackage
`default_nettype wire

FILE: design/gi2d_locate.sv
// One axis of the query: subtract origin, scale by the inverse step and
// split into cell index and weight over two register stages. Uses gi2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gi2d_locate import gi2d_pkg::*; #(
  parameter int MAX_N = 64
) (
  input  wire logic               clk,
  input  wire logic signed [31:0] pos,
  input  wire logic signed [31:0] org,
  input  wire logic        [31:0] inv,
  input  wire logic        [6:0]  cnt,
  output axis_loc_t               loc
);

  localparam int IW = $clog2(MAX_N);

  // stage A: difference magnitude split, multiply low word
  logic signed [32:0] diff;
  logic        [32:0] mag;
  logic               neg_r;
  logic               magh_r;
  logic        [63:0] prod_r;
  logic        [31:0] inv_r;
  logic        [10:0] cnte_r;

  logic        [10:0] cnt_eff;
  always_comb begin
    diff = 33'(pos) - 33'(org);
    mag  = diff[32] ? 33'(-diff) : diff;
    if (11'(cnt) > 11'(MAX_N)) cnt_eff = 11'(MAX_N);
    else cnt_eff = 11'(cnt);
  end

  always_ff @(posedge clk) begin
    neg_r  <= diff[32];
    magh_r <= mag[32];
    prod_r <= 64'(mag[31:0]) * 64'(inv);
    inv_r  <= inv;
    cnte_r <= cnt_eff;
  end

  // stage B: integer part, range checks
  logic [32:0] ip;
  always_comb begin
    ip = 33'(prod_r[63:32]) + (magh_r ? 33'(inv_r) : 33'd0);
  end

  always_ff @(posedge clk) begin
    if (cnte_r < 11'd2) begin
      loc.in_grid <= 1'b0;
      loc.idx     <= '0;
      loc.w       <= '0;
    end else if (neg_r) begin
      loc.in_grid <= (ip == 33'd0);
      loc.idx     <= '0;
      loc.w       <= '0;
    end else if (ip > 33'(cnte_r - 11'd1)) begin
      loc.in_grid <= 1'b0;
      loc.idx     <= '0;
      loc.w       <= '0;
    end else if (ip == 33'(cnte_r - 11'd1)) begin
      loc.in_grid <= 1'b1;
      loc.idx     <= 10'(cnte_r - 11'd2);
      loc.w       <= WEIGHT_ONE;
    end else begin
      loc.in_grid <= 1'b1;
      loc.idx     <= 10'(ip[IW-1:0]);
      loc.w       <= {1'b0, prod_r[31:16]};
    end
  end

endmodule
`default_nettype wire

FILE: design/grid_interpolator_2d.sv
// Top level of the 2D grid interpolator. Instantiates gi2d_locate twice and
// holds the four banked grid memories. Uses gi2d_pkg.
//
// One word enters per cycle whenever start is high; busy is never asserted.
// A query gives its result on out_valid after the locate, corner read,
// blend and output register stages; loads give no result and write the
// grid before a query accepted right behind them reads its corners, so a
// query may follow a load back to back and still see it.
// The pipeline is built from the 32x32 locate multiply, the four-bank corner
// read (banks by row and column parity), and a two-multiply blend pipeline.
// The receiver cannot stall; results must be taken as they appear.
`timescale 1ns / 1ps
`default_nettype none
module grid_interpolator_2d import gi2d_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  in_word_t                   in_word,
  output logic                       out_valid,
  output out_word_t                  out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int BR = (MAX_ROWS + 1) / 2;
  localparam int BC = (MAX_COLS + 1) / 2;
  localparam int BRW = (BR > 1) ? $clog2(BR) : 1;
  localparam int BCW = (BC > 1) ? $clog2(BC) : 1;
  localparam int BD = BR * BC;
  localparam int BAW = $clog2(BD);

  assign busy = 1'b0;

  // configuration registers
  logic        [1:0]  mode_r;
  logic signed [15:0] nil_r;
  logic signed [31:0] row_org_r, col_org_r;
  logic        [31:0] row_inv_r, col_inv_r;
  logic        [6:0]  row_cnt_r, col_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BILINEAR;
      nil_r     <= 16'sh8000;
      row_org_r <= '0;
      col_org_r <= '0;
      row_inv_r <= 32'd65536;
      col_inv_r <= 32'd65536;
      row_cnt_r <= 7'd64;
      col_cnt_r <= 7'd64;
    end else if (cfg_we && cfg_index[3] == 1'b0) begin
      unique case (cfg_index[2:0])
        REG_MODE:         mode_r    <= cfg_data[1:0];
        REG_NIL_VALUE:    nil_r     <= cfg_data[15:0];
        REG_ROW_ORIGIN:   row_org_r <= cfg_data;
        REG_COL_ORIGIN:   col_org_r <= cfg_data;
        REG_ROW_INV_STEP: row_inv_r <= cfg_data;
        REG_COL_INV_STEP: col_inv_r <= cfg_data;
        REG_ROW_COUNT:    row_cnt_r <= cfg_data[6:0];
        REG_COL_COUNT:    col_cnt_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // stages 1..2: locate on both axes; carry kind, load fields alongside
  axis_loc_t rloc, cloc;

  gi2d_locate #(.MAX_N(MAX_ROWS)) u_row (
    .clk(clk), .pos(in_word.query_pos_row), .org(row_org_r),
    .inv(row_inv_r), .cnt(row_cnt_r), .loc(rloc));
  gi2d_locate #(.MAX_N(MAX_COLS)) u_col (
    .clk(clk), .pos(in_word.query_pos_col), .org(col_org_r),
    .inv(col_inv_r), .cnt(col_cnt_r), .loc(cloc));

  logic [1:0] v1_r, v2_r;           // {query, load} valid
  logic [5:0] lr1_r, lc1_r, lr2_r, lc2_r;
  logic [15:0] lv1_r, lv2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= '0;
      v2_r <= '0;
    end else begin
      v1_r <= {start && in_word.kind == KIND_QUERY, start && in_word.kind == KIND_LOAD};
      v2_r <= v1_r;
    end
    lr1_r <= in_word.load_row;
    lc1_r <= in_word.load_col;
    lv1_r <= in_word.load_value;
    lr2_r <= lr1_r;
    lc2_r <= lc1_r;
    lv2_r <= lv1_r;
  end

  // stage 3: bank addresses for the four corners, load write decode
  logic        q3_r, ld3_r, out3_r;
  logic [16:0] wr3_r, wc3_r;
  logic [1:0]  par3_r;              // {row parity, col parity} of the cell
  logic [BRW-1:0] ra_e3_r, ra_o3_r;
  logic [BCW-1:0] ca_e3_r, ca_o3_r;
  logic [1:0]  lbank3_r;
  logic [BAW-1:0] laddr3_r;
  logic [15:0] lv3_r;

  logic [RW-1:0] ri, ri1;
  logic [CW-1:0] ci, ci1;
  logic          ld_ok;
  always_comb begin
    ri  = rloc.idx[RW-1:0];
    ci  = cloc.idx[CW-1:0];
    ri1 = RW'(ri + 1'b1);
    ci1 = CW'(ci + 1'b1);
    ld_ok = (32'(lr2_r) < 32'(MAX_ROWS)) && (32'(lc2_r) < 32'(MAX_COLS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q3_r  <= 1'b0;
      ld3_r <= 1'b0;
    end else begin
      q3_r  <= v2_r[1];
      ld3_r <= v2_r[0] && ld_ok;
    end
    out3_r  <= !(rloc.in_grid && cloc.in_grid);
    wr3_r   <= rloc.w;
    wc3_r   <= cloc.w;
    par3_r  <= {ri[0], ci[0]};
    // even bank holds the even index of the pair, odd the odd one
    ra_e3_r <= BRW'((ri[0] ? ri1 : ri) >> 1);
    ra_o3_r <= BRW'((ri[0] ? ri : ri1) >> 1);
    ca_e3_r <= BCW'((ci[0] ? ci1 : ci) >> 1);
    ca_o3_r <= BCW'((ci[0] ? ci : ci1) >> 1);
    lbank3_r <= {lr2_r[0], lc2_r[0]};
    laddr3_r <= BAW'((32'(lr2_r) >> 1) * BC + (32'(lc2_r) >> 1));
    lv3_r    <= lv2_r;
  end

  // stage 4: read four banks (bank index {row parity, col parity}), write load
  logic [15:0] bank0 [BD];
  logic [15:0] bank1 [BD];
  logic [15:0] bank2 [BD];
  logic [15:0] bank3 [BD];
  logic [15:0] rd_r [4];
  logic [BAW-1:0] a0, a1, a2, a3;
  always_comb begin
    a0 = BAW'(32'(ra_e3_r) * BC + 32'(ca_e3_r));
    a1 = BAW'(32'(ra_e3_r) * BC + 32'(ca_o3_r));
    a2 = BAW'(32'(ra_o3_r) * BC + 32'(ca_e3_r));
    a3 = BAW'(32'(ra_o3_r) * BC + 32'(ca_o3_r));
  end

  always_ff @(posedge clk) begin
    if (ld3_r && lbank3_r == 2'd0) bank0[laddr3_r] <= lv3_r;
    if (ld3_r && lbank3_r == 2'd1) bank1[laddr3_r] <= lv3_r;
    if (ld3_r && lbank3_r == 2'd2) bank2[laddr3_r] <= lv3_r;
    if (ld3_r && lbank3_r == 2'd3) bank3[laddr3_r] <= lv3_r;
    rd_r[0] <= bank0[a0];
    rd_r[1] <= bank1[a1];
    rd_r[2] <= bank2[a2];
    rd_r[3] <= bank3[a3];
  end

  logic        q4_r, out4_r;
  logic [16:0] wr4_r, wc4_r;
  logic [1:0]  par4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) q4_r <= 1'b0;
    else q4_r <= q3_r;
    out4_r <= out3_r;
    wr4_r  <= wr3_r;
    wc4_r  <= wc3_r;
    par4_r <= par3_r;
  end

  // stage 5: unswizzle corners, nil test, nearest pick, first blend
  logic signed [15:0] v00, v01, v10, v11, vn, ba, bb;
  logic               ill, rn, cn, lin;
  logic signed [34:0] lo_nxt, hi_nxt;
  always_comb begin
    v00 = rd_r[{par4_r[1], par4_r[0]}];
    v01 = rd_r[{par4_r[1], ~par4_r[0]}];
    v10 = rd_r[{~par4_r[1], par4_r[0]}];
    v11 = rd_r[{~par4_r[1], ~par4_r[0]}];
    ill = (v00 == nil_r) || (v01 == nil_r) || (v10 == nil_r) || (v11 == nil_r);
    rn  = wr4_r >= HALF_WEIGHT;
    cn  = wc4_r >= HALF_WEIGHT;
    unique case ({rn, cn})
      2'b00:   vn = v00;
      2'b01:   vn = v01;
      2'b10:   vn = v10;
      default: vn = v11;
    endcase
    lin = (mode_r != MODE_NEAREST) && !ill;
    // row blends for bilinear and mode 2; column blends for mode 3
    if (mode_r == MODE_LIN_COLS) begin
      lo_nxt = 35'($signed({1'b0, WEIGHT_ONE - wc4_r})) * 35'(v00)
             + 35'($signed({1'b0, wc4_r})) * 35'(v01);
      hi_nxt = 35'($signed({1'b0, WEIGHT_ONE - wc4_r})) * 35'(v10)
             + 35'($signed({1'b0, wc4_r})) * 35'(v11);
    end else begin
      lo_nxt = 35'($signed({1'b0, WEIGHT_ONE - wr4_r})) * 35'(v00)
             + 35'($signed({1'b0, wr4_r})) * 35'(v10);
      hi_nxt = 35'($signed({1'b0, WEIGHT_ONE - wr4_r})) * 35'(v01)
             + 35'($signed({1'b0, wr4_r})) * 35'(v11);
    end
    ba = 16'sd0;
    bb = 16'sd0;
  end

  logic               q5_r, out5_r, lin5_r, ill5_r, rn5_r, cn5_r;
  logic [16:0]        wc5_r;
  logic signed [15:0] vn5_r;
  logic signed [34:0] lo5_r, hi5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) q5_r <= 1'b0;
    else q5_r <= q4_r;
    out5_r <= out4_r;
    lin5_r <= lin;
    ill5_r <= ill && (mode_r != MODE_NEAREST);
    rn5_r  <= rn;
    cn5_r  <= cn;
    wc5_r  <= wc4_r;
    vn5_r  <= vn + ba + bb;
    lo5_r  <= lo_nxt;
    hi5_r  <= hi_nxt;
  end

  // stage 6: second blend across columns (bilinear), partial products
  logic signed [52:0] pa_nxt, pb_nxt;
  always_comb begin
    pa_nxt = 53'($signed({1'b0, WEIGHT_ONE - wc5_r})) * 53'(lo5_r);
    pb_nxt = 53'($signed({1'b0, wc5_r})) * 53'(hi5_r);
  end

  logic               q6_r, out6_r, lin6_r, ill6_r, rn6_r, cn6_r;
  logic signed [15:0] vn6_r;
  logic signed [34:0] lo6_r, hi6_r;
  logic signed [52:0] pa6_r, pb6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) q6_r <= 1'b0;
    else q6_r <= q5_r;
    out6_r <= out5_r;
    lin6_r <= lin5_r;
    ill6_r <= ill5_r;
    rn6_r  <= rn5_r;
    cn6_r  <= cn5_r;
    vn6_r  <= vn5_r;
    lo6_r  <= lo5_r;
    hi6_r  <= hi5_r;
    pa6_r  <= pa_nxt;
    pb6_r  <= pb_nxt;
  end

  // stage 7: sum, round half up, select by mode
  logic signed [53:0] bil;
  logic signed [34:0] one_d;
  logic signed [15:0] res;
  always_comb begin
    bil = 54'(pa6_r) + 54'(pb6_r) + 54'sd2147483648;
    if (mode_r == MODE_LIN_ROWS) one_d = (cn6_r ? hi6_r : lo6_r) + 35'sd32768;
    else one_d = (rn6_r ? hi6_r : lo6_r) + 35'sd32768;
    if (out6_r) res = nil_r;
    else if (!lin6_r) res = vn6_r;
    else if (mode_r == MODE_BILINEAR) res = bil[47:32];
    else res = one_d[31:16];
  end

  logic      q7_r;
  out_word_t ow7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) q7_r <= 1'b0;
    else q7_r <= q6_r;
    ow7_r.result_value <= res;
    ow7_r.outside_grid <= out6_r;
    ow7_r.used_nearest <= !out6_r && ill6_r;
  end

  // stage 8: output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= q7_r;
    out_word <= ow7_r;
  end

endmodule
`default_nettype wire

FILE: design/gi2d_checker.sv
// Port-level checks for grid_interpolator_2d, attached by bind.
// Uses gi2d_pkg for the word types.
`timescale 1ns / 1ps
`default_nettype none
module gi2d_checker import gi2d_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input in_word_t       in_word,
  input wire logic      out_valid,
  input out_word_t      out_word
);

  // a result comes only after an accepted query, never otherwise
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_word.kind == KIND_QUERY, 8))
    else $error("result without matching query");

  a_query: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.kind == KIND_QUERY |-> ##8 out_valid)
    else $error("query lost");

  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.outside_grid |-> !out_word.used_nearest)
    else $error("outside result flagged nearest");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

endmodule

bind grid_interpolator_2d gi2d_checker u_gi2d_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
  .out_valid(out_valid), .out_word(out_word));
`default_nettype wire
